### src/pma_pkg.sv
`default_nettype none
package pma_pkg;

  localparam int VAL_W       = 32;
  localparam int FRAC_W      = 16;
  localparam int NUM_AXES    = 3;
  localparam int D2_W        = 2 * VAL_W + 2;
  localparam int DIST_W      = VAL_W + 2;
  localparam int SQ_REM_W    = DIST_W + 3;
  localparam int SQRT_STAGES = DIST_W;
  localparam int SQ_RAD_W    = 2 * SQRT_STAGES;
  localparam int NUM_W       = 64;
  localparam int DIV_REM_W   = DIST_W + 1;
  localparam int DIV_STAGES  = NUM_W;
  localparam int RATIO_W     = VAL_W + 1;
  localparam int ACC_W       = 47;
  localparam int DV_W        = ACC_W + 2;
  localparam int CFG_IDX_W   = 3;

  localparam logic [NUM_W-1:0] QUOT_CAP   = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] KILL_RESET = 32'd327680;

  // register indexes of the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTR_MASS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KILL_RADIUS = 3'd5;

  // sideband that rides along the square root
  typedef struct packed {
    logic [NUM_AXES-1:0][VAL_W-1:0] vel;
    logic [NUM_AXES-1:0][VAL_W-1:0] dabs;
    logic [NUM_AXES-1:0]            dneg;
    logic                           mzero;
  } sq_side_t;

  // sideband that rides along the dividers
  typedef struct packed {
    logic [NUM_AXES-1:0][VAL_W-1:0]   vel;
    logic [NUM_AXES-1:0]              dneg;
    logic                             expired;
    logic                             merr;
    logic                             active;
    logic [DIST_W-1:0]                distance;
    logic [NUM_AXES-1:0][RATIO_W-1:0] ratio;
  } flow_t;

endpackage
`default_nettype wire

### src/pma_sqrt.sv
`default_nettype none
module pma_sqrt
  import pma_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [D2_W-1:0]  in_rad,
  input  wire sq_side_t         in_side,
  output logic                  out_valid,
  output logic [DIST_W-1:0]     out_root,
  output sq_side_t              out_side
);

  logic                v_r    [SQRT_STAGES];
  logic [SQ_RAD_W-1:0] rad_r  [SQRT_STAGES];
  logic [SQ_REM_W-1:0] rem_r  [SQRT_STAGES];
  logic [DIST_W-1:0]   root_r [SQRT_STAGES];
  sq_side_t            side_r [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic                src_v;
    logic [SQ_RAD_W-1:0] src_rad;
    logic [SQ_REM_W-1:0] src_rem;
    logic [DIST_W-1:0]   src_root;
    sq_side_t            src_side;
    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;
    logic [SQ_REM_W-1:0] rem_nxt;
    logic [DIST_W-1:0]   root_nxt;

    // pick up the previous stage, or the input for the first one
    if (k == 0) begin : g_first
      assign src_v    = in_valid;
      assign src_rad  = {2'b00, in_rad};
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_side = in_side;
    end else begin : g_next
      assign src_v    = v_r[k-1];
      assign src_rad  = rad_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_root = root_r[k-1];
      assign src_side = side_r[k-1];
    end

    // one root bit per stage
    always_comb begin
      rem_sh = {src_rem[SQ_REM_W-3:0], src_rad[SQ_RAD_W-1 -: 2]};
      trial  = {1'b0, src_root, 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {src_root[DIST_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {src_root[DIST_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= {src_rad[SQ_RAD_W-3:0], 2'b00};
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= src_side;
      end
    end
  end

  assign out_valid = v_r[SQRT_STAGES-1];
  assign out_root  = root_r[SQRT_STAGES-1];
  assign out_side  = side_r[SQRT_STAGES-1];

endmodule
`default_nettype wire

### src/pma_div.sv
`default_nettype none
module pma_div
  import pma_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DIST_W-1:0] den,
  output logic [NUM_W-1:0]       quo
);

  logic [DIV_REM_W-1:0] rem_r [DIV_STAGES];
  logic [NUM_W-1:0]     nq_r  [DIV_STAGES];
  logic [DIST_W-1:0]    den_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DIV_REM_W-1:0] src_rem;
    logic [NUM_W-1:0]     src_nq;
    logic [DIST_W-1:0]    src_den;
    logic [DIV_REM_W-1:0] rem_sh;
    logic [DIV_REM_W-1:0] rem_nxt;
    logic                 qbit;

    if (k == 0) begin : g_first
      assign src_rem = '0;
      assign src_nq  = num;
      assign src_den = den;
    end else begin : g_next
      assign src_rem = rem_r[k-1];
      assign src_nq  = nq_r[k-1];
      assign src_den = den_r[k-1];
    end

    // restoring step: one quotient bit per stage
    always_comb begin
      rem_sh = {src_rem[DIV_REM_W-2:0], src_nq[NUM_W-1]};
      qbit   = (rem_sh >= {1'b0, src_den});
      rem_nxt = qbit ? (rem_sh - {1'b0, src_den}) : rem_sh;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        nq_r[k]  <= {src_nq[NUM_W-2:0], qbit};
        den_r[k] <= src_den;
      end
    end
  end

  assign quo = nq_r[DIV_STAGES-1];

endmodule
`default_nettype wire

### src/pma_delay.sv
`default_nettype none
module pma_delay
  import pma_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire flow_t in_flow,
  output logic       out_valid,
  output flow_t      out_flow
);

  logic  v_r    [DIV_STAGES];
  flow_t flow_r [DIV_STAGES];

  // shift valid and sideband in step with the divider stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < DIV_STAGES; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flow_r[0] <= in_flow;
      for (int k = 1; k < DIV_STAGES; k++) flow_r[k] <= flow_r[k-1];
    end
  end

  assign out_valid = v_r[DIV_STAGES-1];
  assign out_flow  = flow_r[DIV_STAGES-1];

endmodule
`default_nettype wire

### src/point_mass_attractor_step.sv
// Point-mass attractor: pulls one particle per transaction toward a fixed center.
// Input channel in_*: one particle per transaction (position, velocity, mass).
// Output channel out_*: updated velocity plus the expired and mass_error flags.
// Configuration channel cfg_*: register index and data, always ready; write
// only while no particle is in flight.
// The path from input to output: three front stages (offset, squares, sum),
// a 34-stage square root, a classify stage, two 64-stage restoring dividers
// (one quotient bit per stage) with a cap stage between them, and four stages
// of cap, multiply, add and saturate. Throughput is one particle per clock
// while the output is taken; every stage is a register stage.
// The whole pipeline advances together: when the output register holds a
// transaction that the receiver does not take, every stage holds and
// in_tready drops, so nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults: gravity, mass and center zero, kill radius 5.0.
`default_nettype none
module point_mass_attractor_step
  import pma_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, particle_mass
  input  wire logic [7*VAL_W-1:0]   in_tdata,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // new_vel_x, new_vel_y, new_vel_z
  output logic [3*VAL_W-1:0]        out_tdata,
  // expired, mass_error
  output logic [1:0]                out_tuser,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [VAL_W-1:0]     cfg_data
);

  logic en;

  logic [VAL_W-1:0] gravity_r, attr_mass_r, kill_radius_r;
  logic [NUM_AXES-1:0][VAL_W-1:0] center_r;
  logic [2*VAL_W-1:0] prod_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r     <= '0;
      attr_mass_r   <= '0;
      center_r      <= '0;
      kill_radius_r <= KILL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRAVITY:     gravity_r     <= cfg_data;
        REG_ATTR_MASS:   attr_mass_r   <= cfg_data;
        REG_CENTER_X:    center_r[0]   <= cfg_data;
        REG_CENTER_Y:    center_r[1]   <= cfg_data;
        REG_CENTER_Z:    center_r[2]   <= cfg_data;
        REG_KILL_RADIUS: kill_radius_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // gravity times attractor mass, settles long before any particle needs it
  always_ff @(posedge clk) begin
    prod_r <= gravity_r * attr_mass_r;
  end

  // the pipeline moves as one while the output register can take a transaction
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: offset from the center
  logic v1_r;
  logic [NUM_AXES-1:0][VAL_W:0]   d1_r;
  logic [NUM_AXES-1:0][VAL_W-1:0] vel1_r;
  logic mz1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        d1_r[i]   <= {in_tdata[i*VAL_W + VAL_W-1], in_tdata[i*VAL_W +: VAL_W]}
                   - {center_r[i][VAL_W-1], center_r[i]};
        vel1_r[i] <= in_tdata[(i+3)*VAL_W +: VAL_W];
      end
      mz1_r <= (in_tdata[6*VAL_W +: VAL_W] == '0);
    end
  end

  // stage 2: magnitudes and squares
  logic v2_r;
  logic [NUM_AXES-1:0][2*VAL_W-1:0] sq2_r;
  sq_side_t side2_r;
  logic [NUM_AXES-1:0][VAL_W-1:0] dabs1;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      dabs1[i] = d1_r[i][VAL_W] ? VAL_W'(-d1_r[i]) : d1_r[i][VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        sq2_r[i]         <= dabs1[i] * dabs1[i];
        side2_r.dneg[i]  <= d1_r[i][VAL_W];
      end
      side2_r.dabs  <= dabs1;
      side2_r.vel   <= vel1_r;
      side2_r.mzero <= mz1_r;
    end
  end

  // stage 3: sum of squares
  logic v3_r;
  logic [D2_W-1:0] d2_3_r;
  sq_side_t side3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_3_r  <= {2'b00, sq2_r[0]} + {2'b00, sq2_r[1]} + {2'b00, sq2_r[2]};
      side3_r <= side2_r;
    end
  end

  // distance
  logic v4;
  logic [DIST_W-1:0] dist4;
  sq_side_t side4;

  pma_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_rad    (d2_3_r),
    .in_side   (side3_r),
    .out_valid (v4),
    .out_root  (dist4),
    .out_side  (side4)
  );

  // stage 5: classify, build the first set of numerators
  logic v5_r;
  flow_t flow5_r;
  logic [NUM_W-1:0] numq5_r;
  logic [NUM_AXES-1:0][NUM_W-1:0] numr5_r;
  logic exp4;

  assign exp4 = (dist4 < {2'b00, kill_radius_r});

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flow5_r.vel      <= side4.vel;
      flow5_r.dneg     <= side4.dneg;
      flow5_r.expired  <= exp4;
      flow5_r.merr     <= !exp4 && side4.mzero;
      flow5_r.active   <= !exp4 && !side4.mzero && (dist4 != '0);
      flow5_r.distance <= dist4;
      flow5_r.ratio    <= '0;
      numq5_r          <= {prod_r[2*VAL_W-1:FRAC_W], {FRAC_W{1'b0}}};
      for (int i = 0; i < NUM_AXES; i++) begin
        numr5_r[i] <= {side4.dabs[i], {VAL_W{1'b0}}};
      end
    end
  end

  // first division pass: K / r and the three direction ratios
  logic v6;
  flow_t flow6;
  logic [NUM_W-1:0] q6;
  logic [NUM_AXES-1:0][NUM_W-1:0] r6;

  pma_delay u_delay1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .in_flow   (flow5_r),
    .out_valid (v6),
    .out_flow  (flow6)
  );

  pma_div u_div_q (
    .clk (clk),
    .en  (en),
    .num (numq5_r),
    .den (flow5_r.distance),
    .quo (q6)
  );

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_ratio
    pma_div u_div_r (
      .clk (clk),
      .en  (en),
      .num (numr5_r[a]),
      .den (flow5_r.distance),
      .quo (r6[a])
    );
  end

  // stage 7: cap the first quotient, keep the ratios
  logic v7_r;
  flow_t flow7_r;
  flow_t flow6_rat;
  logic [NUM_W-1:0] numa7_r;
  logic [NUM_W-1:0] qcap6;

  assign qcap6 = (q6 > QUOT_CAP) ? QUOT_CAP : q6;

  always_comb begin
    flow6_rat = flow6;
    for (int i = 0; i < NUM_AXES; i++) begin
      flow6_rat.ratio[i] = r6[i][RATIO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (en) v7_r <= v6;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flow7_r <= flow6_rat;
      numa7_r <= {1'b0, qcap6[ACC_W-1:0], {FRAC_W{1'b0}}};
    end
  end

  // second division pass: acceleration magnitude
  logic v8;
  flow_t flow8;
  logic [NUM_W-1:0] a8;

  pma_delay u_delay2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v7_r),
    .in_flow   (flow7_r),
    .out_valid (v8),
    .out_flow  (flow8)
  );

  pma_div u_div_a (
    .clk (clk),
    .en  (en),
    .num (numa7_r),
    .den (flow7_r.distance),
    .quo (a8)
  );

  // stage 9: cap the acceleration
  logic v9_r;
  flow_t flow9_r;
  logic [ACC_W-1:0] acc9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v9_r <= 1'b0;
    else if (en) v9_r <= v8;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flow9_r <= flow8;
      acc9_r  <= (a8 > QUOT_CAP) ? QUOT_CAP[ACC_W-1:0] : a8[ACC_W-1:0];
    end
  end

  // stage 10: partial products of acceleration times ratio
  logic v10_r;
  flow_t flow10_r;
  logic [NUM_AXES-1:0][ACC_W-VAL_W+RATIO_W-1:0] ph10_r;
  logic [NUM_AXES-1:0][VAL_W+RATIO_W-1:0]       pl10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v10_r <= 1'b0;
    else if (en) v10_r <= v9_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flow10_r <= flow9_r;
      for (int i = 0; i < NUM_AXES; i++) begin
        ph10_r[i] <= acc9_r[ACC_W-1:VAL_W] * flow9_r.ratio[i];
        pl10_r[i] <= acc9_r[VAL_W-1:0] * flow9_r.ratio[i];
      end
    end
  end

  // stage 11: combine partial products into the velocity change
  logic v11_r;
  flow_t flow11_r;
  logic [NUM_AXES-1:0][DV_W-1:0] dv11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v11_r <= 1'b0;
    else if (en) v11_r <= v10_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flow11_r <= flow10_r;
      for (int i = 0; i < NUM_AXES; i++) begin
        dv11_r[i] <= DV_W'(ph10_r[i]) + DV_W'(pl10_r[i][VAL_W+RATIO_W-1:VAL_W]);
      end
    end
  end

  // stage 12: apply, saturate, output register
  logic out_valid_r;
  logic [NUM_AXES-1:0][VAL_W-1:0] nv_r;
  logic expired_r, merr_r;
  logic [NUM_AXES-1:0][VAL_W-1:0] nv_nxt;
  logic signed [DV_W:0] velx;
  logic signed [DV_W:0] dvx;
  logic signed [DV_W:0] sum;

  always_comb begin
    velx = '0;
    dvx  = '0;
    sum  = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      velx = {{(DV_W+1-VAL_W){flow11_r.vel[i][VAL_W-1]}}, flow11_r.vel[i]};
      dvx  = {1'b0, dv11_r[i]};
      sum  = flow11_r.dneg[i] ? (velx + dvx) : (velx - dvx);
      if (!flow11_r.active) begin
        nv_nxt[i] = flow11_r.vel[i];
      end else if (sum > $signed({{(DV_W+2-VAL_W){1'b0}}, {(VAL_W-1){1'b1}}})) begin
        nv_nxt[i] = {1'b0, {(VAL_W-1){1'b1}}};
      end else if (sum < $signed({{(DV_W+2-VAL_W){1'b1}}, {(VAL_W-1){1'b0}}})) begin
        nv_nxt[i] = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
        nv_nxt[i] = sum[VAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= v11_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nv_r      <= nv_nxt;
      expired_r <= flow11_r.expired;
      merr_r    <= flow11_r.merr;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = nv_r;
  assign out_tuser  = {merr_r, expired_r};

  // at most one flag on any result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("expired and mass_error both set");

  // a flagged particle is never pulled
  assert property (@(posedge clk) disable iff (!rst_n)
    (flow11_r.expired || flow11_r.merr) |-> !flow11_r.active)
    else $error("flagged particle marked active");

  // the pipeline is empty right after reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // input stalls exactly when the held result is not taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

endmodule
`default_nettype wire

### dv/tb_top.sv
`default_nettype none
module tb_top;
  import pma_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY    = 171;
  localparam int STALL_LIMIT = 20000;

  // an index past the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic        expired;
    logic        merr;
  } vel_update_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7*VAL_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [3*VAL_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0] cfg_data = '0;

  // shadow copy of the configuration registers
  logic [31:0] gravity_q, amass_q, kill_q;
  logic signed [31:0] center_q [3];

  vel_update_t pending_updates [$];
  int errors = 0;
  int idle_pct = 24;
  int stall_cycles = 0;

  point_mass_attractor_step u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [33:0] isqrt66(logic [65:0] v);
    logic [67:0] rem;
    logic [33:0] root;
    logic [67:0] trial;
    logic [67:0] vw;
    rem = '0;
    root = '0;
    vw = {2'b00, v};
    for (int i = 33; i >= 0; i--) begin
      rem = (rem << 2) | 68'(vw[2*i +: 2]);
      trial = (68'(root) << 2) | 68'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 34'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // compute the velocity update for one particle
  function automatic vel_update_t attract(logic [7*VAL_W-1:0] p);
    logic signed [33:0] d [3];
    logic signed [63:0] v [3];
    logic signed [63:0] nv [3];
    logic [65:0] d2;
    logic [33:0] distance, ad;
    logic [127:0] k, q, a, ratio, dv;
    logic signed [127:0] res;
    vel_update_t r;
    d2 = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 34'($signed(p[32*i +: 32])) - 34'(center_q[i]);
      v[i] = 64'($signed(p[32*(i+3) +: 32]));
      nv[i] = v[i];
      ad = d[i] < 0 ? -d[i] : d[i];
      d2 = d2 + 66'(ad) * 66'(ad);
    end
    distance = isqrt66(d2);
    r.expired = 1'b0;
    r.merr = 1'b0;
    if (distance < 34'(kill_q)) begin
      r.expired = 1'b1;
    end else if (p[6*32 +: 32] == 32'd0) begin
      r.merr = 1'b1;
    end else if (distance != 0) begin
      k = (128'(gravity_q) * 128'(amass_q)) >> 16;
      q = (k << 16) / 128'(distance);
      if (q > 128'(QUOT_CAP)) q = 128'(QUOT_CAP);
      a = (q << 16) / 128'(distance);
      if (a > 128'(QUOT_CAP)) a = 128'(QUOT_CAP);
      for (int i = 0; i < 3; i++) begin
        ad = d[i] < 0 ? -d[i] : d[i];
        ratio = (128'(ad) << 32) / 128'(distance);
        dv = (a * ratio) >> 32;
        res = d[i] < 0 ? 128'(v[i]) + $signed(dv) : 128'(v[i]) - $signed(dv);
        if (res > 128'sd2147483647) res = 128'sd2147483647;
        if (res < -128'sd2147483648) res = -128'sd2147483648;
        nv[i] = 64'(res);
      end
    end
    r.vx = nv[0][31:0];
    r.vy = nv[1][31:0];
    r.vz = nv[2][31:0];
    return r;
  endfunction

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random backpressure, compare each result
  always @(posedge clk) begin
    vel_update_t exp_u;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_updates.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        exp_u = pending_updates.pop_front();
        if (out_tdata[31:0] !== exp_u.vx) begin
          $error("new_vel_x exp %h got %h", exp_u.vx, out_tdata[31:0]); errors++;
        end
        if (out_tdata[63:32] !== exp_u.vy) begin
          $error("new_vel_y exp %h got %h", exp_u.vy, out_tdata[63:32]); errors++;
        end
        if (out_tdata[95:64] !== exp_u.vz) begin
          $error("new_vel_z exp %h got %h", exp_u.vz, out_tdata[95:64]); errors++;
        end
        if (out_tuser[0] !== exp_u.expired) begin
          $error("expired exp %b got %b", exp_u.expired, out_tuser[0]); errors++;
        end
        if (out_tuser[1] !== exp_u.merr) begin
          $error("mass_error exp %b got %b", exp_u.merr, out_tuser[1]); errors++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= idle_pct);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GRAVITY:     gravity_q = val;
      REG_ATTR_MASS:   amass_q = val;
      REG_CENTER_X:    center_q[0] = val;
      REG_CENTER_Y:    center_q[1] = val;
      REG_CENTER_Z:    center_q[2] = val;
      REG_KILL_RADIUS: kill_q = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic [31:0] g, logic [31:0] m, logic [31:0] cx,
                           logic [31:0] cy, logic [31:0] cz, logic [31:0] kr);
    write_reg(REG_GRAVITY, g);
    write_reg(REG_ATTR_MASS, m);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_KILL_RADIUS, kr);
  endtask

  // send one particle, with random idle cycles ahead of it
  task automatic send_particle(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                               logic [31:0] m);
    logic [7*VAL_W-1:0] p;
    p = {m, vz, vy, vx, pz, py, px};
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_updates.push_back(attract(p));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000000)) - 1000000);
      2: return 32'($signed($urandom_range(60000000)) - 30000000);
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(2))
      0: return $urandom();
      1: return 32'($signed($urandom_range(400000)) - 200000);
      default: return $urandom_range(1) ? 32'h7FFF_FFF0 : 32'h8000_0010;
    endcase
  endfunction

  task automatic send_random();
    send_particle(rnd_coord(), rnd_coord(), rnd_coord(), rnd_val(), rnd_val(),
                  rnd_val(), ($urandom_range(15) == 0) ? 32'd0 : $urandom());
  endtask

  // reset defaults, then extremes of fields and each special case
  task automatic test_directed();
    send_particle(32'd0, 32'd0, 32'd0, 32'd5, -32'd5, 32'd7, 32'h10000);
    drain();
    configure(32'h10000, 32'h10000, 32'd0, 32'd0, 32'd0, 32'h50000);
    send_particle(32'h10000, 32'd0, 32'd0, 32'd1, 32'd2, 32'd3, 32'h10000);
    send_particle(32'h100000, 32'h100000, -32'h100000, 32'd100, 32'd0, -32'd9, 32'h10000);
    send_particle(32'h100000, 32'd0, 32'd0, 32'd1, 32'd1, 32'd1, 32'd0);
    send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'd0, 32'hFFFF_FFFF);
    send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
    // large pull: quotient caps and velocity saturation
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'd0);
    send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd3, 32'd4, 32'd5, 32'd1);
    send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd3, 32'd4, 32'd5, 32'd0);
    send_particle(32'h7FFF_FFFE, 32'h8000_0001, 32'h7FFF_FFFF, 32'h7FFF_0000,
                  32'h8000_FFFF, 32'd0, 32'd1);
    send_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'd0, 32'd1);
    send_particle(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
    drain();
    configure(32'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd2, 32'd3, 32'd0);
    send_particle(32'd0, 32'd0, 32'd0, 32'd1, 32'd2, 32'd3, 32'd1);
    drain();
    write_reg(REG_UNUSED, 32'h1234_5678);
    send_particle(32'd0, 32'd0, 32'd0, 32'd1, 32'd2, 32'd3, 32'd1);
    drain();
  endtask

  // random particles across several register settings
  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: configure(32'h10000, 32'h10000, 32'd0, 32'd0, 32'd0, 32'h50000);
        1: configure($urandom(), $urandom(), rnd_coord(), rnd_coord(), rnd_coord(),
                     $urandom_range(200000));
        2: configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, rnd_coord(), rnd_coord(),
                     rnd_coord(), 32'd0);
        3: configure($urandom_range(65536 * 100), $urandom_range(65536 * 1000),
                     rnd_coord(), rnd_coord(), rnd_coord(), $urandom());
        4: configure($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom());
        default: configure($urandom(), $urandom(), 32'd0, 32'd0, 32'd0, 32'h50000);
      endcase
      idle_pct = (phase == 2) ? 0 : 24;
      for (int n = 0; n < 105; n++) send_random();
      drain();
    end
    idle_pct = 24;
  endtask

  initial begin
    gravity_q = '0;
    amass_q = '0;
    kill_q = KILL_RESET;
    for (int i = 0; i < 3; i++) center_q[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    repeat (LATENCY) @(posedge clk);
    if (errors == 0 && pending_updates.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
